// ===== hdl/u8dw_pkg.sv =====
// u8dw_pkg: shared types, constants and helpers for utf8_display_width.
// No dependencies; u8dw_step, utf8_display_width and tb_top import it.
package u8dw_pkg;

  localparam int WIDTH_BITS = 16;
  localparam int CP_BITS    = 21;
  localparam int OUT_BITS   = 16;

  localparam logic [CP_BITS-1:0] WIDE0_LO = 21'h001100;
  localparam logic [CP_BITS-1:0] WIDE0_HI = 21'h00115F;
  localparam logic [CP_BITS-1:0] WIDE1_LO = 21'h002E80;
  localparam logic [CP_BITS-1:0] WIDE1_HI = 21'h00A4CF;
  localparam logic [CP_BITS-1:0] WIDE2_LO = 21'h00AC00;
  localparam logic [CP_BITS-1:0] WIDE2_HI = 21'h00D7A3;
  localparam logic [CP_BITS-1:0] WIDE3_LO = 21'h00F900;
  localparam logic [CP_BITS-1:0] WIDE3_HI = 21'h00FAFF;
  localparam logic [CP_BITS-1:0] WIDE4_LO = 21'h00FF00;
  localparam logic [CP_BITS-1:0] WIDE4_HI = 21'h00FF60;
  localparam logic [CP_BITS-1:0] WIDE5_LO = 21'h00FFE0;
  localparam logic [CP_BITS-1:0] WIDE5_HI = 21'h00FFE6;

  // decoder state carried between words
  typedef struct packed {
    logic [1:0]         pend;   // continuation words still expected
    logic [CP_BITS-1:0] cp;     // code point built so far
    logic [7:0]         held0;  // first continuation word of the open sequence
    logic [1:0]         hcnt;   // continuation words taken so far
  } dec_state_t;

  function automatic logic cp_is_wide(input logic [CP_BITS-1:0] cp);
    logic w;
    w = ((cp >= WIDE0_LO) && (cp <= WIDE0_HI)) ||
        ((cp >= WIDE1_LO) && (cp <= WIDE1_HI)) ||
        ((cp >= WIDE2_LO) && (cp <= WIDE2_HI)) ||
        ((cp >= WIDE3_LO) && (cp <= WIDE3_HI)) ||
        ((cp >= WIDE4_LO) && (cp <= WIDE4_HI)) ||
        ((cp >= WIDE5_LO) && (cp <= WIDE5_HI));
    return w;
  endfunction

endpackage

// ===== hdl/u8dw_in_if.sv =====
// u8dw_in_if: valid/ready channel carrying one string byte per word.
// Depends on nothing.
interface u8dw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_string;

  modport source (output valid, output text_byte, output end_of_string, input ready);
  modport sink   (input valid, input text_byte, input end_of_string, output ready);
endinterface

// ===== hdl/u8dw_out_if.sv =====
// u8dw_out_if: valid/ready channel carrying one display width per word.
// Depends on nothing.
interface u8dw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] display_width;

  modport source (output valid, output display_width, input ready);
  modport sink   (input valid, input display_width, output ready);
endinterface

// ===== hdl/u8dw_step.sv =====
// u8dw_step: combinational UTF-8 decode step and width increment for one byte.
// Depends on u8dw_pkg.
module u8dw_step (
  input  u8dw_pkg::dec_state_t st,
  input  logic [7:0]           byte_in,
  input  logic                 last,
  output u8dw_pkg::dec_state_t st_nxt,
  output logic [1:0]           inc
);
  import u8dw_pkg::*;

  logic [CP_BITS-1:0] cp_shift;
  logic [1:0]         step_inc;
  logic [1:0]         scan;

  assign cp_shift = {st.cp[CP_BITS-7:0], byte_in[5:0]};

  always_comb begin
    st_nxt   = st;
    step_inc = 2'd0;
    if (st.pend == 2'd0) begin
      if (byte_in[7:5] == 3'b110) begin
        st_nxt.pend = 2'd1;
        st_nxt.cp   = CP_BITS'(byte_in[4:0]);
        st_nxt.hcnt = 2'd0;
      end else if (byte_in[7:4] == 4'b1110) begin
        st_nxt.pend = 2'd2;
        st_nxt.cp   = CP_BITS'(byte_in[3:0]);
        st_nxt.hcnt = 2'd0;
      end else if (byte_in[7:3] == 5'b11110) begin
        st_nxt.pend = 2'd3;
        st_nxt.cp   = CP_BITS'(byte_in[2:0]);
        st_nxt.hcnt = 2'd0;
      end else begin
        step_inc = 2'd1;  // ASCII or invalid lead
      end
    end else begin
      if (st.hcnt == 2'd0) begin
        st_nxt.held0 = byte_in;
      end
      st_nxt.hcnt = st.hcnt + 2'd1;
      st_nxt.cp   = cp_shift;
      st_nxt.pend = st.pend - 2'd1;
      if (st.pend == 2'd1) begin
        step_inc    = cp_is_wide(cp_shift) ? 2'd2 : 2'd1;
        st_nxt.hcnt = 2'd0;
      end
    end
  end

  // rescan of at most two held bytes: only a 2-byte lead followed by one byte pairs up
  always_comb begin
    case (st_nxt.hcnt)
      2'd0:    scan = 2'd0;
      2'd1:    scan = 2'd1;
      default: scan = (st_nxt.held0[7:5] == 3'b110) ? 2'd1 : 2'd2;
    endcase
  end

  always_comb begin
    if (last && (st_nxt.pend != 2'd0)) begin
      inc = 2'd1 + scan;
    end else begin
      inc = step_inc;
    end
  end

endmodule

// ===== hdl/utf8_display_width.sv =====
// utf8_display_width: display width of a UTF-8 string, one byte per word.
// The accepted byte is registered in byte1_r; the width is registered in out_width_r when out_free.
// Throughput: one byte per cycle; results stall only on out_ch.ready.
// Reset: synchronous active-low rst_n clears the decoder state, running total
// and both valid flags; the block accepts input on the first cycle after reset.
module utf8_display_width (
  input  logic         clk,
  input  logic         rst_n,
  u8dw_in_if.sink      in_ch,
  u8dw_out_if.source   out_ch
);
  import u8dw_pkg::*;

  logic                  v1_r;
  logic [7:0]            byte1_r;
  logic                  last1_r;
  dec_state_t            st_r;
  dec_state_t            st_step;
  logic [1:0]            inc;
  logic [WIDTH_BITS-1:0] total_r;
  logic [WIDTH_BITS:0]   sum;
  logic [WIDTH_BITS-1:0] sat;
  logic [WIDTH_BITS+OUT_BITS-1:0] sat_ext;
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_width_r;
  logic                  out_free;
  logic                  go;

  u8dw_step u_step (
    .st      (st_r),
    .byte_in (byte1_r),
    .last    (last1_r),
    .st_nxt  (st_step),
    .inc     (inc)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign go          = v1_r && (!last1_r || out_free);
  assign in_ch.ready = !v1_r || go;

  assign sum     = {1'b0, total_r} + (WIDTH_BITS+1)'(inc);
  assign sat     = sum[WIDTH_BITS] ? {WIDTH_BITS{1'b1}} : sum[WIDTH_BITS-1:0];
  assign sat_ext = {{OUT_BITS{1'b0}}, sat};

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte1_r <= in_ch.text_byte;
      last1_r <= in_ch.end_of_string;
    end
    if (go && last1_r) begin
      out_width_r <= sat_ext[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      st_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        v1_r <= in_ch.valid;
      end
      if (go) begin
        if (last1_r) begin
          st_r    <= '0;
          total_r <= '0;
        end else begin
          st_r    <= st_step;
          total_r <= sat;
        end
      end
      if (go && last1_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.display_width = out_width_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for utf8_display_width, with a table of directed
// strings and then random well-formed and broken strings under varied flow control.
// Depends on hdl/u8dw_pkg.sv, hdl/u8dw_in_if.sv, hdl/u8dw_out_if.sv and the block.
module tb_top;
  import u8dw_pkg::*;

  localparam int     HOLD_CYCLES = 300;
  localparam int     IDLE_LIMIT  = 2000;
  localparam int     DRAIN       = 20;
  localparam int     PHASE_BYTES = 450;
  localparam longint TOTAL_MAX   = (longint'(1) << WIDTH_BITS) - 1;

  typedef struct packed {
    logic [7:0]  b;
    logic        eos;
    logic        typed;
    logic [15:0] w;
  } str_row_t;

  logic clk;
  logic rst_n;

  u8dw_in_if  in_ch ();
  u8dw_out_if out_ch ();

  utf8_display_width dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // decoder mirror
  logic [1:0]         dec_pend;
  logic [CP_BITS-1:0] dec_cp;
  logic [7:0]         dec_held [3];
  logic [1:0]         dec_hcnt;
  longint             run_cols;

  logic [15:0] width_q [$];
  logic [7:0]  str_q [$];
  logic [15:0] want_w;
  int          errors;
  int          idle_cycles;
  int          snd_idle_pct;
  int          rcv_stall_pct;
  logic        hold_req;

  logic [CP_BITS-1:0] wide_lo [6];
  logic [CP_BITS-1:0] wide_hi [6];

  str_row_t dir_tbl [23];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int lead_span(input logic [7:0] b, output logic [CP_BITS-1:0] bits);
    bits = '0;
    if (b[7] == 1'b0) begin
      bits[6:0] = b[6:0];
      return 1;
    end
    if (b[7:5] == 3'b110) begin
      bits[4:0] = b[4:0];
      return 2;
    end
    if (b[7:4] == 4'b1110) begin
      bits[3:0] = b[3:0];
      return 3;
    end
    if (b[7:3] == 5'b11110) begin
      bits[2:0] = b[2:0];
      return 4;
    end
    return 0;
  endfunction

  function automatic int cp_columns(input logic [CP_BITS-1:0] cp);
    int i;
    for (i = 0; i < 6; i++) begin
      if (cp >= wide_lo[i] && cp <= wide_hi[i]) return 2;
    end
    return 1;
  endfunction

  function automatic int rescan_columns(input logic [7:0] run [3], input int n);
    int w;
    int i;
    int len;
    int k;
    logic [CP_BITS-1:0] cp;
    w = 0;
    i = 0;
    while (i < n) begin
      len = lead_span(run[i], cp);
      if (len == 0 || i + len > n) begin
        w++;
        i++;
      end else begin
        for (k = 1; k < len; k++) cp = {cp[CP_BITS-7:0], run[i+k][5:0]};
        w += cp_columns(cp);
        i += len;
      end
    end
    return w;
  endfunction

  task automatic add_cols(input longint c);
    run_cols = (run_cols + c > TOTAL_MAX) ? TOTAL_MAX : run_cols + c;
  endtask

  task automatic clear_decoder();
    dec_pend = '0;
    dec_cp   = '0;
    dec_held = '{8'h00, 8'h00, 8'h00};
    dec_hcnt = '0;
    run_cols = 0;
  endtask

  task automatic width_step(input logic [7:0] b, input logic eos,
                            output logic got, output logic [15:0] w);
    int len;
    logic [CP_BITS-1:0] bits;
    got = 1'b0;
    w   = '0;
    if (dec_pend == 2'd0) begin
      len = lead_span(b, bits);
      if (len <= 1) begin
        add_cols(1);
      end else begin
        dec_pend = 2'(len - 1);
        dec_cp   = bits;
        dec_hcnt = '0;
      end
    end else begin
      if (dec_hcnt < 2'd3) begin
        dec_held[dec_hcnt] = b;
        dec_hcnt++;
      end
      dec_cp = {dec_cp[CP_BITS-7:0], b[5:0]};
      dec_pend--;
      if (dec_pend == 2'd0) begin
        add_cols(cp_columns(dec_cp));
        dec_hcnt = '0;
      end
    end
    if (eos) begin
      if (dec_pend != 2'd0) begin
        add_cols(1);
        add_cols(rescan_columns(dec_held, int'(dec_hcnt)));
      end
      got = 1'b1;
      w   = run_cols[15:0];
      clear_decoder();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos,
                           input logic typed, input logic [15:0] typed_w);
    logic got;
    logic [15:0] w;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.text_byte     <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    width_step(b, eos, got, w);
    if (got) width_q = {width_q, (typed ? typed_w : w)};
  endtask

  task automatic add_byte(input logic [7:0] b);
    str_q = {str_q, b};
  endtask

  task automatic put_char(input logic [CP_BITS-1:0] cp, input int n);
    int k;
    case (n)
      2:       add_byte({3'b110, cp[10:6]});
      3:       add_byte({4'b1110, cp[15:12]});
      4:       add_byte({5'b11110, cp[20:18]});
      default: add_byte({1'b0, cp[6:0]});
    endcase
    for (k = n - 2; k >= 0; k--) begin
      if ($urandom_range(0, 99) < 3) add_byte(8'($urandom_range(0, 255)));
      else add_byte({2'b10, cp[6*k +: 6]});
    end
  endtask

  task automatic build_string();
    int nchars;
    int c;
    int pick;
    int r;
    int n;
    int m;
    logic [CP_BITS-1:0] cp;
    str_q.delete();
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
    for (c = 0; c < nchars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        put_char(CP_BITS'($urandom_range(0, 127)), 1);
      end else if (pick < 50) begin
        put_char(CP_BITS'($urandom_range(32'h80, 32'h7FF)), 2);
      end else if (pick < 70) begin
        r = $urandom_range(0, 5);
        case ($urandom_range(0, 7))
          0:       cp = wide_lo[r] - CP_BITS'(1);
          1:       cp = wide_lo[r];
          2:       cp = wide_hi[r];
          3:       cp = wide_hi[r] + CP_BITS'(1);
          default: cp = CP_BITS'($urandom_range(wide_lo[r], wide_hi[r]));
        endcase
        put_char(cp, 3);
      end else if (pick < 80) begin
        put_char(CP_BITS'($urandom_range(32'h800, 32'hFFFF)), 3);
      end else if (pick < 88) begin
        put_char(CP_BITS'($urandom_range(32'h10000, 32'h1FFFFF)), 4);
      end else if (pick < 94) begin
        if ($urandom_range(0, 1)) add_byte(8'($urandom_range(8'h80, 8'hBF)));
        else add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    // string cut inside a sequence
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(2, 4);
      m = $urandom_range(0, n - 2);
      case (n)
        2:       add_byte(8'h C0 | 8'($urandom_range(0, 31)));
        3:       add_byte(8'hE0 | 8'($urandom_range(0, 15)));
        default: add_byte(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
      for (c = 0; c < m; c++) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req     <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (width_q.size() == 0) begin
        $display("%0t ns: display_width expected none, got %0d", $time,
                 out_ch.display_width);
        errors++;
      end else begin
        want_w = width_q.pop_front();
        if (out_ch.display_width !== want_w) begin
          $display("%0t ns: display_width expected %0d, got %0d", $time, want_w,
                   out_ch.display_width);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int k;
    int ph;
    int sent;
    int snd_pct [4];
    int rcv_pct [4];

    snd_pct = '{0, 74, 0, 27};
    rcv_pct = '{0, 0, 74, 27};
    wide_lo = '{WIDE0_LO, WIDE1_LO, WIDE2_LO, WIDE3_LO, WIDE4_LO, WIDE5_LO};
    wide_hi = '{WIDE0_HI, WIDE1_HI, WIDE2_HI, WIDE3_HI, WIDE4_HI, WIDE5_HI};
    dir_tbl = '{
      '{8'h00, 1'b1, 1'b1, 16'd1},   // smallest byte
      '{8'h7F, 1'b1, 1'b1, 16'd1},   // largest single-byte char
      '{8'h80, 1'b1, 1'b1, 16'd1},   // stray continuation as lead
      '{8'hFF, 1'b1, 1'b1, 16'd1},   // 11111xxx lead
      '{8'hE1, 1'b0, 1'b0, 16'd0},   // U+1100, first wide code point
      '{8'h84, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b1, 1'b1, 16'd2},
      '{8'hEF, 1'b0, 1'b0, 16'd0},   // U+FFE6, last wide code point
      '{8'hBF, 1'b0, 1'b0, 16'd0},
      '{8'hA6, 1'b1, 1'b1, 16'd2},
      '{8'hC3, 1'b0, 1'b0, 16'd0},   // two-byte char
      '{8'hA9, 1'b1, 1'b0, 16'd0},
      '{8'hF0, 1'b0, 1'b0, 16'd0},   // four-byte char
      '{8'h9F, 1'b0, 1'b0, 16'd0},
      '{8'h98, 1'b0, 1'b0, 16'd0},
      '{8'h80, 1'b1, 1'b0, 16'd0},
      '{8'hE4, 1'b1, 1'b0, 16'd0},   // ends on a bare lead
      '{8'hF0, 1'b0, 1'b0, 16'd0},   // unchecked continuations, then cut
      '{8'h41, 1'b0, 1'b0, 16'd0},
      '{8'h42, 1'b1, 1'b0, 16'd0},
      '{8'hF0, 1'b0, 1'b0, 16'd0},   // cut, and cut again on rescan
      '{8'hE4, 1'b0, 1'b0, 16'd0},
      '{8'hB8, 1'b1, 1'b0, 16'd0}
    };

    errors        = 0;
    idle_cycles   = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_req      = 1'b0;
    clear_decoder();

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.text_byte     <= 8'h00;
    in_ch.end_of_string <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < 23; i++)
      send_byte(dir_tbl[i].b, dir_tbl[i].eos, dir_tbl[i].typed, dir_tbl[i].w);

    for (ph = 0; ph < 4; ph++) begin
      snd_idle_pct  = snd_pct[ph];
      rcv_stall_pct <= rcv_pct[ph];
      if (ph == 0) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_string();
        for (k = 0; k < str_q.size(); k++)
          send_byte(str_q[k], k == str_q.size() - 1, 1'b0, 16'h0000);
        sent += str_q.size();
      end
    end

    in_ch.valid <= 1'b0;
    while (width_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
